>>> rtl/ftoa_pkg.sv
`default_nettype none
package ftoa_pkg;
  localparam int unsigned MAX_FRAC_DIGITS = 9;
  localparam logic [3:0] FRAC_RESET = 4'd4;
  localparam logic [30:0] SAT_INT = 31'h7fffffff;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_DOT = 8'h2e;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam int unsigned INT_DIGITS = 10;
  localparam int unsigned BCD_W = 4 * INT_DIGITS;

  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [30:0] ipart;
    logic [29:0] fdig;
    logic [3:0]  nfrac;
  } ftoa_item_t;

  function automatic logic [29:0] pow10(input logic [3:0] d);
    logic [29:0] r;
    r = 30'd1;
    case (d)
      4'd0: r = 30'd1;
      4'd1: r = 30'd10;
      4'd2: r = 30'd100;
      4'd3: r = 30'd1000;
      4'd4: r = 30'd10000;
      4'd5: r = 30'd100000;
      4'd6: r = 30'd1000000;
      4'd7: r = 30'd10000000;
      4'd8: r = 30'd100000000;
      4'd9: r = 30'd1000000000;
      default: r = 30'd1;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

>>> rtl/ftoa_front.sv
`default_nettype none
module ftoa_front #(
  parameter int unsigned MAX_FRAC_DIGITS = ftoa_pkg::MAX_FRAC_DIGITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [31:0]          in_float_bits,
  input  wire logic [3:0]           frac_digits,
  input  wire logic                 q_full,
  output logic                      busy,
  output logic                      q_push,
  output ftoa_pkg::ftoa_item_t      q_item
);
  // stage 1: classify and align; stage 2: fraction multiply and shift
  logic        v1_r, v1_nxt;
  logic        neg1_r, ovf1_r;
  logic [30:0] ip1_r;
  logic [63:0] fr1_r;
  logic [5:0]  sh1_r;
  logic [3:0]  d1_r;
  logic        zero_sh1_r;

  logic        sign, is_nan, is_zero, ovf, fz;
  logic [7:0]  expf;
  logic [23:0] mant;
  logic [9:0]  e;
  logic [7:0]  s;
  logic [30:0] ip;
  logic [63:0] frac;
  logic [3:0]  d;
  logic [63:0] v;
  logic [93:0] prod;
  logic [93:0] shd;

  assign sign = in_float_bits[31];
  assign expf = in_float_bits[30:23];
  assign is_nan = (expf == 8'hff) && (in_float_bits[22:0] != 23'd0);
  assign is_zero = (expf == 8'h00) && (in_float_bits[22:0] == 23'd0);
  assign d = (frac_digits > 4'(MAX_FRAC_DIGITS)) ? 4'(MAX_FRAC_DIGITS) : frac_digits;

  always_comb begin
    mant = (expf == 8'h00) ? {1'b0, in_float_bits[22:0]} : {1'b1, in_float_bits[22:0]};
    e = (expf == 8'h00) ? -10'sd149 : 10'({2'b00, expf}) - 10'd150;
    ovf = 1'b0;
    ip = 31'd0;
    frac = 64'd0;
    s = 8'd0;
    fz = 1'b0;
    v = 64'd0;
    if (expf == 8'hff) begin
      ovf = 1'b1;
    end else if (!e[9]) begin
      if (e >= 10'd40) begin
        ovf = 1'b1;
      end else begin
        v = {40'd0, mant} << e[5:0];
        if (v >= 64'h80000000) ovf = 1'b1;
        else ip = v[30:0];
      end
    end else begin
      s = 8'(-e);
      if (s >= 8'd64) begin
        fz = 1'b1;
      end else begin
        ip = 31'({40'd0, mant} >> s[5:0]);
        frac = {40'd0, mant} & ((64'd1 << s[5:0]) - 64'd1);
      end
    end
    if (ovf) ip = ftoa_pkg::SAT_INT;
  end

  assign busy = v1_r && q_full;
  assign v1_nxt = start && !busy ? 1'b1 : (busy ? v1_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= v1_nxt;
    if (start && !busy) begin
      neg1_r <= sign && !is_nan && !is_zero;
      ovf1_r <= ovf;
      ip1_r <= ip;
      fr1_r <= frac;
      sh1_r <= s[5:0];
      d1_r <= d;
      zero_sh1_r <= fz || ovf;
    end
  end

  // frac < 2^24, 10^d < 2^30
  assign prod = 94'(fr1_r[23:0] * ftoa_pkg::pow10(d1_r));
  assign shd = prod >> sh1_r;

  assign q_push = v1_r && !q_full;
  always_comb begin
    q_item.neg = neg1_r;
    q_item.ovf = ovf1_r;
    q_item.ipart = ip1_r;
    q_item.fdig = zero_sh1_r ? 30'd0 : shd[29:0];
    q_item.nfrac = d1_r;
  end
endmodule
`default_nettype wire

>>> rtl/ftoa_queue.sv
`default_nettype none
module ftoa_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire ftoa_pkg::ftoa_item_t push_item,
  input  wire logic                 pop,
  output logic                      full,
  output logic                      not_empty,
  output ftoa_pkg::ftoa_item_t      head
);
  ftoa_pkg::ftoa_item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head = mem_r[rp_r];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= push_item;
  end
endmodule
`default_nettype wire

>>> rtl/ftoa_back.sv
`default_nettype none
module ftoa_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  input  wire ftoa_pkg::ftoa_item_t q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  output logic [7:0]                out_text_char,
  output logic                      out_last_char,
  output logic                      out_overflow
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CONV = 6'b000010,
    S_SIGN = 6'b000100,
    S_INT  = 6'b001000,
    S_DOT  = 6'b010000,
    S_FRAC = 6'b100000
  } state_t;

  localparam int unsigned W = ftoa_pkg::BCD_W;

  state_t      st_r, st_nxt;
  logic [30:0] bin_r;
  logic [W-1:0] ib_r;
  logic [W-1:0] fb_r;
  logic [5:0]  cyc_r;
  logic [3:0]  nint_r, nfrac_r, idx_r;
  logic        neg_r, ovf_r;
  logic [29:0] fbin_r;
  logic [W-1:0] ib_adj, fb_adj;
  logic [W-1:0] ib_sh;
  logic [3:0]  ndig;

  // double dabble, both parts in parallel, one bit per cycle
  always_comb begin
    ib_adj = ib_r;
    fb_adj = fb_r;
    for (int i = 0; i < ftoa_pkg::INT_DIGITS; i++) begin
      if (ib_r[4*i +: 4] >= 4'd5) ib_adj[4*i +: 4] = ib_r[4*i +: 4] + 4'd3;
      if (fb_r[4*i +: 4] >= 4'd5) fb_adj[4*i +: 4] = fb_r[4*i +: 4] + 4'd3;
    end
    ib_sh = {ib_adj[W-2:0], bin_r[30]};
    ndig = 4'd1;
    for (int i = 1; i < ftoa_pkg::INT_DIGITS; i++) begin
      if (ib_sh[4*i +: 4] != 4'd0) ndig = 4'(i + 1);
    end
  end

  assign q_pop = (st_r == S_IDLE) && q_valid;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (q_valid) st_nxt = S_CONV;
      S_CONV: if (cyc_r == 6'd30) st_nxt = neg_r ? S_SIGN : S_INT;
      S_SIGN: st_nxt = S_INT;
      S_INT:  if (idx_r == 4'd1) st_nxt = (nfrac_r != 4'd0) ? S_DOT : S_IDLE;
      S_DOT:  st_nxt = S_FRAC;
      S_FRAC: if (idx_r == 4'd1) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid <= (st_r == S_SIGN) || (st_r == S_INT) || (st_r == S_DOT) || (st_r == S_FRAC);
    end
    out_overflow <= ovf_r;
    out_last_char <= 1'b0;
    out_text_char <= ftoa_pkg::CH_ZERO;
    case (st_r)
      S_IDLE: begin
        bin_r <= q_item.ipart;
        fbin_r <= q_item.fdig;
        neg_r <= q_item.neg;
        ovf_r <= q_item.ovf;
        nfrac_r <= q_item.nfrac;
        ib_r <= '0;
        fb_r <= '0;
        cyc_r <= 6'd0;
      end
      S_CONV: begin
        if (cyc_r < 6'd31) begin
          ib_r <= ib_sh;
          bin_r <= {bin_r[29:0], 1'b0};
        end
        if (cyc_r < 6'd30) begin
          fb_r <= {fb_adj[W-2:0], fbin_r[29]};
          fbin_r <= {fbin_r[28:0], 1'b0};
        end
        cyc_r <= cyc_r + 6'd1;
        if (cyc_r == 6'd30) idx_r <= ndig;
      end
      S_SIGN: out_text_char <= ftoa_pkg::CH_MINUS;
      S_INT: begin
        out_text_char <= ftoa_pkg::CH_ZERO | {4'd0, ib_r[4*(idx_r-4'd1) +: 4]};
        out_last_char <= (idx_r == 4'd1) && (nfrac_r == 4'd0);
        idx_r <= idx_r - 4'd1;
      end
      S_DOT: begin
        out_text_char <= ftoa_pkg::CH_DOT;
        idx_r <= nfrac_r;
      end
      S_FRAC: begin
        out_text_char <= ftoa_pkg::CH_ZERO | {4'd0, fb_r[4*(idx_r-4'd1) +: 4]};
        out_last_char <= idx_r == 4'd1;
        idx_r <= idx_r - 4'd1;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/float_to_decimal_ascii.sv
// path to the first char: front register, queue, bit-serial conversion in the back end, output register
// the back end converts one value at a time with the bit-serial bcd converter
// front and back are split by a 2-entry queue so the next value is taken early
// synchronous active-low reset clears control and sets frac_digits to 4
// the receiver cannot stall: out_valid marks each char for one cycle
`default_nettype none
module float_to_decimal_ascii #(
  parameter int unsigned MAX_FRAC_DIGITS = ftoa_pkg::MAX_FRAC_DIGITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_float_bits,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_frac_digits,
  output logic             out_valid,
  output logic [7:0]       out_text_char,
  output logic             out_last_char,
  output logic             out_overflow
);
  logic [3:0] frac_digits_r;
  logic q_full, q_push, q_ne, q_pop;
  ftoa_pkg::ftoa_item_t q_in, q_head;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) frac_digits_r <= ftoa_pkg::FRAC_RESET;
    else if (cfg_valid) frac_digits_r <= cfg_frac_digits;
  end

  ftoa_front #(.MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)) u_front (
    .clk, .rst_n, .start, .in_float_bits, .frac_digits(frac_digits_r),
    .q_full, .busy, .q_push, .q_item(q_in)
  );

  ftoa_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_item(q_in), .pop(q_pop),
    .full(q_full), .not_empty(q_ne), .head(q_head)
  );

  ftoa_back u_back (
    .clk, .rst_n, .q_valid(q_ne), .q_item(q_head), .q_pop,
    .out_valid, .out_text_char, .out_last_char, .out_overflow
  );
endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none

class text_scoreboard;
  logic [7:0] exp_char[$];
  logic       exp_last[$];
  logic       exp_ovf[$];
  int         errors;
  int         values_seen;
  int         chars_checked;

  function new();
    errors = 0;
    values_seen = 0;
    chars_checked = 0;
  endfunction

  function void push(logic [7:0] ch, logic ovf);
    exp_char.push_back(ch);
    exp_last.push_back(1'b0);
    exp_ovf.push_back(ovf);
  endfunction

  // builds the expected text of one float word for the given digit count
  function void note_value(logic [31:0] bits, logic [3:0] frac_cfg);
    logic        sgn;
    logic [7:0]  expf;
    logic [63:0] mant;
    logic [63:0] frac;
    logic [63:0] fdig;
    logic [63:0] v;
    logic [63:0] p10;
    logic [31:0] ipart;
    logic        ovf;
    logic        is_nan;
    logic        is_zero;
    int          d;
    int          e;
    int          n;
    int          i;
    logic [7:0]  digs[10];
    sgn = bits[31];
    expf = bits[30:23];
    mant = {41'd0, bits[22:0]};
    d = (frac_cfg > 9) ? 9 : frac_cfg;
    ipart = 0;
    fdig = 0;
    ovf = 0;
    is_nan = (expf == 8'hff) && (mant != 0);
    is_zero = (expf == 0) && (mant == 0);
    p10 = 1;
    for (i = 0; i < d; i++) p10 = p10 * 10;
    if (expf == 8'hff) begin
      ovf = 1;
      ipart = 32'h7fffffff;
    end else begin
      if (expf == 0) begin
        e = -149;
      end else begin
        mant[23] = 1'b1;
        e = int'(expf) - 150;
      end
      if (e >= 0) begin
        if (e >= 40) begin
          ovf = 1;
        end else begin
          v = mant << e;
          if (v >= 64'h80000000) ovf = 1;
          else ipart = v[31:0];
        end
        if (ovf) ipart = 32'h7fffffff;
      end else if (-e >= 64) begin
        ipart = 0;
        fdig = 0;
      end else begin
        ipart = 32'(mant >> (-e));
        frac = mant & ((64'd1 << (-e)) - 1);
        fdig = (frac * p10) >> (-e);
      end
    end
    if (sgn && !is_nan && !is_zero) push(ftoa_pkg::CH_MINUS, ovf);
    n = 0;
    do begin
      digs[n] = ftoa_pkg::CH_ZERO + 8'(ipart % 10);
      n++;
      ipart = ipart / 10;
    end while (ipart != 0 && n < 10);
    while (n > 0) begin
      n--;
      push(digs[n], ovf);
    end
    if (d != 0) begin
      push(ftoa_pkg::CH_DOT, ovf);
      for (i = 0; i < d; i++) begin
        p10 = p10 / 10;
        push(ftoa_pkg::CH_ZERO + 8'((fdig / p10) % 10), ovf);
      end
    end
    exp_last[$] = 1'b1;
    values_seen++;
  endfunction

  function void check_char(logic [7:0] ch, logic last, logic ovf);
    logic [7:0] ec;
    logic       el;
    logic       eo;
    if (exp_char.size() == 0) begin
      $error("unexpected char %h with nothing pending", ch);
      errors++;
      return;
    end
    ec = exp_char.pop_front();
    el = exp_last.pop_front();
    eo = exp_ovf.pop_front();
    chars_checked++;
    if (ch !== ec) begin
      $error("text_char mismatch: expected %h actual %h", ec, ch);
      errors++;
    end
    if (last !== el) begin
      $error("last_char mismatch: expected %b actual %b", el, last);
      errors++;
    end
    if (ovf !== eo) begin
      $error("overflow mismatch: expected %b actual %b", eo, ovf);
      errors++;
    end
  endfunction

  function int pending();
    return exp_char.size();
  endfunction
endclass

module tb_top;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [31:0] in_float_bits = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [3:0]  cfg_frac_digits = 0;
  logic        out_valid;
  logic [7:0]  out_text_char;
  logic        out_last_char;
  logic        out_overflow;

  text_scoreboard sb = new();
  logic [3:0] cur_digits = ftoa_pkg::FRAC_RESET;
  int burst_left = 0;

  float_to_decimal_ascii dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_float_bits(in_float_bits), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_frac_digits(cfg_frac_digits), .out_valid(out_valid),
    .out_text_char(out_text_char), .out_last_char(out_last_char),
    .out_overflow(out_overflow)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_char(out_text_char, out_last_char, out_overflow);
  end

  // start stays high within a burst; a new burst begins after a gap
  task automatic send_word(input logic [31:0] bits);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_float_bits <= bits;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_value(bits, cur_digits);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic set_digits(input logic [3:0] d);
    drain();
    cfg_frac_digits <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cur_digits = d;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 5))
      0: r[30:23] = $urandom_range(110, 135);
      1: r[30:23] = $urandom_range(150, 160);
      2: r[30:23] = $urandom_range(120, 127);
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    logic [31:0] directed[$];
    int i;
    directed = '{32'h00000000, 32'h80000000, 32'h3f800000, 32'hbf800000,
                 32'h3fc00000, 32'h40490fdb, 32'hc2f6e979, 32'h4effffff,
                 32'h4f000000, 32'hcf000000, 32'h7f7fffff, 32'h7f800000,
                 32'hff800000, 32'h7fc00000, 32'hffc00001, 32'h00000001,
                 32'h807fffff, 32'h3f7fffff, 32'h3dcccccd, 32'h4b7fffff,
                 32'hffffffff, 32'h5f800000};
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[k]) send_word(directed[k]);
    set_digits(4'd0);
    for (i = 0; i < 6; i++) send_word(directed[i * 3]);
    set_digits(4'd9);
    for (i = 0; i < 8; i++) send_word(directed[i * 2 + 1]);
    set_digits(4'd15);
    send_word(32'h3f7fffff);
    send_word(32'h40490fdb);
    for (i = 0; i < 62; i++) begin
      if (i % 20 == 19) set_digits(4'($urandom_range(0, 15)));
      if (i == 50) drain();
      send_word(rand_float());
    end
    drain();
    $display("covered %0d values, %0d chars, digit counts 0 to 15 incl. saturation",
             sb.values_seen, sb.chars_checked);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
